### hw/rtl/csc_pkg.sv
// Shared constants for the congruence system combiner.
`timescale 1ns / 1ps
package csc_pkg;
   localparam int VALUE_BITS = 64;
   localparam int WORD_BITS = 64;
   localparam logic [WORD_BITS-1:0] MOD_LIMIT =
      WORD_BITS'((65'd1 << (VALUE_BITS - 1)) - 65'd1);
   localparam logic [WORD_BITS-1:0] WRAP_MODULUS = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_INCONSISTENT = 2'd1;
   localparam logic [1:0] ST_BAD_MODULUS  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW     = 2'd3;

   function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                    input logic [WORD_BITS-1:0] y,
                                                    input logic [WORD_BITS-1:0] n);
      logic [WORD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, n}) begin
         s = s - {1'b0, n};
      end
      return s[WORD_BITS-1:0];
   endfunction
endpackage

### hw/rtl/csc_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module csc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[63]};
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

### hw/rtl/csc_mulmod.sv
// Shift-and-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module csc_mulmod (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic [63:0] modulus,
   output logic        done,
   output logic [63:0] product
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] n_ff, n_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      if (go) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         n_in    = modulus;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = csc_pkg::add_mod(acc_ff, a_ff, n_ff);
            end
            a_in = csc_pkg::add_mod(a_ff, a_ff, n_ff);
            b_in = {1'b0, b_ff[63:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### hw/rtl/congruence_system_combiner_core.sv
// Top level: generalized CRT combiner, sequencer over a shared divider and multiplier.
`timescale 1ns / 1ps
// Usage:
//   req_* channel: one congruence x = residue (mod modulus) per item. An item
//   is taken when req_valid is high and req_stall is low. req_first_item
//   clears the running system before the merge; req_last_item asks for a
//   result. rsp_* channel: solution, combined modulus and status, one item
//   per last input item, taken when rsp_valid is high and rsp_stall is low.
//   Each merge runs on one 64-step restoring divider and one shift-add
//   modular multiplier. A merge takes 7 divisions and 3 products plus one
//   division per Euclid step of the gcd and two operations per step of the
//   inverse search. Items with a latched error or a bad modulus go straight
//   to the final step.
//   req_stall is high while an item is in work. The result sits in an output
//   register; while the receiver stalls it, a finished last item waits in the
//   final step and no new item is taken.
//   Reset (synchronous) empties the output, idles the sequencer and sets the
//   system to x = 0 (mod 1) with status ok.
module congruence_system_combiner_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_residue,
   input  logic signed [63:0] req_modulus,
   input  logic               req_first_item,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [62:0]        rsp_solution,
   output logic [62:0]        rsp_combined_modulus,
   output logic [1:0]         rsp_status
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_R2   = 4'd1;   // residue reduction
   localparam logic [3:0] S_GCD  = 4'd2;   // Euclid steps
   localparam logic [3:0] S_CONS = 4'd3;   // difference divisible by g
   localparam logic [3:0] S_A    = 4'd4;   // running modulus / g
   localparam logic [3:0] S_LIM  = 4'd5;   // overflow bound
   localparam logic [3:0] S_NEWM = 4'd6;   // lcm product
   localparam logic [3:0] S_N    = 4'd7;   // modulus / g
   localparam logic [3:0] S_Q    = 4'd8;   // reduced lift target
   localparam logic [3:0] S_AN   = 4'd9;   // a mod n, inverse setup
   localparam logic [3:0] S_IQ   = 4'd10;  // inverse: quotient step
   localparam logic [3:0] S_IM   = 4'd11;  // inverse: coefficient update
   localparam logic [3:0] S_T0   = 4'd12;  // lift factor
   localparam logic [3:0] S_MT   = 4'd13;  // lifted residue
   localparam logic [3:0] S_FIN  = 4'd14;  // emit result for a last item

   logic [3:0]  state_ff, state_in;
   logic [1:0]  st_ff, st_in;
   logic [62:0] rr_ff, rr_in;
   logic [62:0] rm_ff, rm_in;
   logic        last_ff, last_in;
   logic        rneg_ff, rneg_in;
   logic        neg_ff, neg_in;
   logic [63:0] m2_ff, m2_in;
   logic [63:0] r2_ff, r2_in;
   logic [63:0] gb_ff, gb_in;
   logic [63:0] g_ff, g_in;
   logic [63:0] magq_ff, magq_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] newm_ff, newm_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] nt_ff, nt_in;
   logic [63:0] nr_ff, nr_in;
   logic [63:0] rn_ff, rn_in;

   logic        div_go_ff, div_go_in;
   logic [63:0] div_x_ff, div_x_in;
   logic [63:0] div_y_ff, div_y_in;
   logic        mm_go_ff, mm_go_in;
   logic [63:0] mm_a_ff, mm_a_in;
   logic [63:0] mm_b_ff, mm_b_in;
   logic [63:0] mm_n_ff, mm_n_in;

   logic        out_v_ff, out_v_in;
   logic [62:0] sol_ff, sol_in;
   logic [62:0] cm_ff, cm_in;
   logic [1:0]  ost_ff, ost_in;

   logic        div_done, mm_done;
   logic [63:0] div_quo, div_rem, mm_prod;

   logic [63:0] res_u, mod_u, rr64, rm64, qred, qadj, sub_term;
   logic [64:0] tsum;
   logic        take;
   logic [1:0]  st_eff;

   csc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go_ff),
      .dividend  (div_x_ff),
      .divisor   (div_y_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   csc_mulmod u_mm (
      .clock   (clock),
      .reset   (reset),
      .go      (mm_go_ff),
      .op_a    (mm_a_ff),
      .op_b    (mm_b_ff),
      .modulus (mm_n_ff),
      .done    (mm_done),
      .product (mm_prod)
   );

   assign res_u = req_residue;
   assign mod_u = req_modulus;
   assign rr64  = {1'b0, rr_ff};
   assign rm64  = {1'b0, rm_ff};
   assign take  = req_valid && !req_stall;
   assign qred  = (div_quo >= n_ff) ? div_quo - n_ff : div_quo;
   assign qadj  = (neg_ff && div_rem != '0) ? n_ff - div_rem : div_rem;
   assign sub_term = n_ff - mm_prod;
   assign tsum  = {1'b0, t_ff} + {1'b0, sub_term};
   assign st_eff = req_first_item ? csc_pkg::ST_OK : st_ff;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      rr_in    = rr_ff;
      rm_in    = rm_ff;
      last_in  = last_ff;
      rneg_in  = rneg_ff;
      neg_in   = neg_ff;
      m2_in    = m2_ff;
      r2_in    = r2_ff;
      gb_in    = gb_ff;
      g_in     = g_ff;
      magq_in  = magq_ff;
      a_in     = a_ff;
      newm_in  = newm_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      t_in     = t_ff;
      nt_in    = nt_ff;
      nr_in    = nr_ff;
      rn_in    = rn_ff;
      div_go_in = 1'b0;
      div_x_in  = div_x_ff;
      div_y_in  = div_y_ff;
      mm_go_in  = 1'b0;
      mm_a_in   = mm_a_ff;
      mm_b_in   = mm_b_ff;
      mm_n_in   = mm_n_ff;
      out_v_in  = out_v_ff && rsp_stall;
      sol_in    = sol_ff;
      cm_in     = cm_ff;
      ost_in    = ost_ff;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               last_in = req_last_item;
               if (req_first_item) begin
                  rr_in = '0;
                  rm_in = 63'd1;
               end
               st_in = st_eff;
               if (st_eff != csc_pkg::ST_OK) begin
                  state_in = S_FIN;
               end else if (mod_u[63] || mod_u == '0) begin
                  st_in    = csc_pkg::ST_BAD_MODULUS;
                  state_in = S_FIN;
               end else begin
                  // reduce the magnitude of the residue first
                  m2_in     = mod_u;
                  rneg_in   = res_u[63];
                  div_go_in = 1'b1;
                  div_x_in  = res_u[63] ? 64'(~res_u + 64'd1) : res_u;
                  div_y_in  = mod_u;
                  state_in  = S_R2;
               end
               if (req_first_item && st_eff == csc_pkg::ST_OK) begin
                  rr_in = '0;
                  rm_in = 63'd1;
               end
            end
         end
         S_R2: begin
            if (div_done) begin
               r2_in = (rneg_ff && div_rem != '0) ? m2_ff - div_rem : div_rem;
               gb_in = m2_ff;
               div_go_in = 1'b1;
               div_x_in  = rm64;
               div_y_in  = m2_ff;
               state_in  = S_GCD;
            end
         end
         S_GCD: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  // gcd found: test the residue difference against it
                  g_in   = gb_ff;
                  neg_in = r2_ff < rr64;
                  div_go_in = 1'b1;
                  div_x_in  = (r2_ff < rr64) ? rr64 - r2_ff : r2_ff - rr64;
                  div_y_in  = gb_ff;
                  state_in  = S_CONS;
               end else begin
                  gb_in = div_rem;
                  div_go_in = 1'b1;
                  div_x_in  = gb_ff;
                  div_y_in  = div_rem;
               end
            end
         end
         S_CONS: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  st_in    = csc_pkg::ST_INCONSISTENT;
                  state_in = S_FIN;
               end else begin
                  magq_in   = div_quo;
                  div_go_in = 1'b1;
                  div_x_in  = rm64;
                  div_y_in  = g_ff;
                  state_in  = S_A;
               end
            end
         end
         S_A: begin
            if (div_done) begin
               a_in      = div_quo;
               div_go_in = 1'b1;
               div_x_in  = csc_pkg::MOD_LIMIT;
               div_y_in  = m2_ff;
               state_in  = S_LIM;
            end
         end
         S_LIM: begin
            if (div_done) begin
               if (a_ff > div_quo) begin
                  st_in    = csc_pkg::ST_OVERFLOW;
                  state_in = S_FIN;
               end else begin
                  // product fits, so wrapping at 2^63 leaves it exact
                  mm_go_in = 1'b1;
                  mm_a_in  = a_ff;
                  mm_b_in  = m2_ff;
                  mm_n_in  = csc_pkg::WRAP_MODULUS;
                  state_in = S_NEWM;
               end
            end
         end
         S_NEWM: begin
            if (mm_done) begin
               newm_in   = mm_prod;
               div_go_in = 1'b1;
               div_x_in  = m2_ff;
               div_y_in  = g_ff;
               state_in  = S_N;
            end
         end
         S_N: begin
            if (div_done) begin
               n_in      = div_quo;
               div_go_in = 1'b1;
               div_x_in  = magq_ff;
               div_y_in  = div_quo;
               state_in  = S_Q;
            end
         end
         S_Q: begin
            if (div_done) begin
               q_in  = qadj;
               t_in  = '0;
               nt_in = (n_ff == 64'd1) ? 64'd0 : 64'd1;
               div_go_in = 1'b1;
               div_x_in  = a_ff;
               div_y_in  = n_ff;
               state_in  = S_AN;
            end
         end
         S_AN: begin
            if (div_done) begin
               nr_in = div_rem;
               if (div_rem == '0) begin
                  mm_go_in = 1'b1;
                  mm_a_in  = q_ff;
                  mm_b_in  = t_ff;
                  mm_n_in  = n_ff;
                  state_in = S_T0;
               end else begin
                  div_go_in = 1'b1;
                  div_x_in  = n_ff;
                  div_y_in  = div_rem;
                  state_in  = S_IQ;
               end
            end
         end
         S_IQ: begin
            if (div_done) begin
               rn_in    = div_rem;
               mm_go_in = 1'b1;
               mm_a_in  = qred;
               mm_b_in  = nt_ff;
               mm_n_in  = n_ff;
               state_in = S_IM;
            end
         end
         S_IM: begin
            if (mm_done) begin
               t_in  = nt_ff;
               nt_in = (tsum >= {1'b0, n_ff}) ? 64'(tsum - {1'b0, n_ff}) : tsum[63:0];
               nr_in = rn_ff;
               if (rn_ff == '0) begin
                  // inverse is the coefficient just retired
                  mm_go_in = 1'b1;
                  mm_a_in  = q_ff;
                  mm_b_in  = nt_ff;
                  mm_n_in  = n_ff;
                  state_in = S_T0;
               end else begin
                  div_go_in = 1'b1;
                  div_x_in  = nr_ff;
                  div_y_in  = rn_ff;
                  state_in  = S_IQ;
               end
            end
         end
         S_T0: begin
            if (mm_done) begin
               mm_go_in = 1'b1;
               mm_a_in  = rm64;
               mm_b_in  = mm_prod;
               mm_n_in  = csc_pkg::WRAP_MODULUS;
               state_in = S_MT;
            end
         end
         S_MT: begin
            if (mm_done) begin
               rr_in    = 63'(rr64 + mm_prod);
               rm_in    = newm_ff[62:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               ost_in   = st_ff;
               sol_in   = (st_ff == csc_pkg::ST_OK) ? rr_ff : '0;
               cm_in    = (st_ff == csc_pkg::ST_OK) ? rm_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         st_ff     <= csc_pkg::ST_OK;
         rr_ff     <= '0;
         rm_ff     <= 63'd1;
         div_go_ff <= 1'b0;
         mm_go_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         st_ff     <= st_in;
         rr_ff     <= rr_in;
         rm_ff     <= rm_in;
         div_go_ff <= div_go_in;
         mm_go_ff  <= mm_go_in;
         out_v_ff  <= out_v_in;
      end
      last_ff  <= last_in;
      rneg_ff  <= rneg_in;
      neg_ff   <= neg_in;
      m2_ff    <= m2_in;
      r2_ff    <= r2_in;
      gb_ff    <= gb_in;
      g_ff     <= g_in;
      magq_ff  <= magq_in;
      a_ff     <= a_in;
      newm_ff  <= newm_in;
      n_ff     <= n_in;
      q_ff     <= q_in;
      t_ff     <= t_in;
      nt_ff    <= nt_in;
      nr_ff    <= nr_in;
      rn_ff    <= rn_in;
      div_x_ff <= div_x_in;
      div_y_ff <= div_y_in;
      mm_a_ff  <= mm_a_in;
      mm_b_ff  <= mm_b_in;
      mm_n_ff  <= mm_n_in;
      sol_ff   <= sol_in;
      cm_ff    <= cm_in;
      ost_ff   <= ost_in;
   end

   // hold off new items until the sequencer is back in idle
   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = out_v_ff;
   assign rsp_solution         = sol_ff;
   assign rsp_combined_modulus = cm_ff;
   assign rsp_status           = ost_ff;
endmodule

### verif/csc_checker.sv
// Checker for the congruence system combiner: predicts each result and compares it.
`timescale 1ns / 1ps
module csc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [63:0] req_residue,
   input  logic signed [63:0] req_modulus,
   input  logic               req_first_item,
   input  logic               req_last_item,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [62:0]        rsp_solution,
   input  logic [62:0]        rsp_combined_modulus,
   input  logic [1:0]         rsp_status,
   output int                 failures,
   output int                 outstanding
);
   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [62:0] solution;
      logic [62:0] modulus;
      logic [1:0]  status;
   } crt_result_type;

   crt_result_type pending_results[$];

   // combined system x = sys_residue (mod sys_modulus)
   u64_type    sys_residue;
   u64_type    sys_modulus;
   logic [1:0] sys_status;

   function automatic u64_type mulmod(u64_type a, u64_type b, u64_type n);
      u64_type acc;
      acc = 0;
      a = a % n;
      b = b % n;
      while (b != 0) begin
         if (b[0]) acc = csc_pkg::add_mod(acc, a, n);
         a = csc_pkg::add_mod(a, a, n);
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic u64_type invmod(u64_type a, u64_type n);
      u64_type t, nt, r, nr, q, tmp;
      t = 0;
      nt = 1 % n;
      r = n;
      nr = a % n;
      while (nr != 0) begin
         q = r / nr;
         tmp = (t + (n - mulmod(q, nt, n))) % n;
         t = nt;
         nt = tmp;
         tmp = r - q * nr;
         r = nr;
         nr = tmp;
      end
      return t;
   endfunction

   // merge one congruence into the running system, latching the first error
   task automatic fold_congruence(u64_type res_bits, u64_type mod_bits);
      u64_type m2, r2, g, a, b, mag, q, n, t0, rem;
      logic neg;
      if (mod_bits == 0 || mod_bits[63]) begin
         sys_status = csc_pkg::ST_BAD_MODULUS;
         return;
      end
      m2 = mod_bits;
      if (!res_bits[63]) begin
         r2 = res_bits % m2;
      end else begin
         rem = (~res_bits + 1) % m2;
         r2 = (rem == 0) ? 0 : m2 - rem;
      end
      a = sys_modulus;
      b = m2;
      while (b != 0) begin
         rem = a % b;
         a = b;
         b = rem;
      end
      g = a;
      neg = r2 < sys_residue;
      mag = neg ? sys_residue - r2 : r2 - sys_residue;
      if (mag % g != 0) begin
         sys_status = csc_pkg::ST_INCONSISTENT;
         return;
      end
      a = sys_modulus / g;
      if (a > csc_pkg::MOD_LIMIT / m2) begin
         sys_status = csc_pkg::ST_OVERFLOW;
         return;
      end
      n = m2 / g;
      q = (mag / g) % n;
      if (neg && q != 0) q = n - q;
      t0 = mulmod(q, invmod(a, n), n);
      sys_residue = (sys_residue + sys_modulus * t0) & 64'h7FFF_FFFF_FFFF_FFFF;
      sys_modulus = (a * m2) & 64'h7FFF_FFFF_FFFF_FFFF;
   endtask

   task automatic report(string field, u64_type got, u64_type want);
      $display("mismatch %s: got %0d, expected %0d", field, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      crt_result_type want;
      if (reset) begin
         sys_residue = 0;
         sys_modulus = 1;
         sys_status  = csc_pkg::ST_OK;
         pending_results.delete();
         failures    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report("unexpected result item, status", rsp_status, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_solution !== want.solution)
                  report("solution", rsp_solution, want.solution);
               if (rsp_combined_modulus !== want.modulus)
                  report("combined_modulus", rsp_combined_modulus, want.modulus);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_first_item) begin
               sys_residue = 0;
               sys_modulus = 1;
               sys_status  = csc_pkg::ST_OK;
            end
            if (sys_status == csc_pkg::ST_OK)
               fold_congruence(req_residue, req_modulus);
            if (req_last_item) begin
               want.status   = sys_status;
               want.solution = (sys_status == csc_pkg::ST_OK) ? sys_residue[62:0] : '0;
               want.modulus  = (sys_status == csc_pkg::ST_OK) ? sys_modulus[62:0] : '0;
               pending_results.push_back(want);
            end
         end
      end
      outstanding = pending_results.size();
   end
endmodule

### verif/tb.sv
// Top of the congruence system combiner testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
   localparam int STALL_LIMIT = 200000;
   localparam int ITEM_TARGET = 1170;
   localparam longint MOD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint RES_MIN = 64'sh8000_0000_0000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [63:0] req_residue = '0;
   logic signed [63:0] req_modulus = 64'sd1;
   logic               req_first_item = 1'b0;
   logic               req_last_item = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [62:0]        rsp_solution;
   logic [62:0]        rsp_combined_modulus;
   logic [1:0]         rsp_status;
   int                 failures;
   int                 outstanding;
   int                 items_sent = 0;
   int                 quiet_cycles = 0;
   bit                 no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   congruence_system_combiner_core dut (.*);

   csc_checker checker_i (.*);

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[congruence_system_combiner_core] ERROR");
         $finish;
      end
   end

   // Receiver: hold stall for a random number of cycles before each result item.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Present one item; enter and leave at a falling edge. Valid stays high on
   // exit so that a back-to-back item needs only one assignment per step.
   task automatic send(longint res, longint modv, bit first, bit last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_residue    <= res;
      req_modulus    <= modv;
      req_first_item <= first;
      req_last_item  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // Pick a modulus: mostly small, sometimes wide, rarely invalid.
   function automatic longint pick_modulus();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return $urandom_range(1, 2000);
      if (sel < 85) return longint'({$urandom, $urandom} >> $urandom_range(1, 40));
      if (sel < 90) return MOD_MAX;
      if (sel < 94) return longint'({$urandom, $urandom}) | RES_MIN;
      if (sel < 96) return 0;
      return $urandom_range(1, 64);
   endfunction

   // One system of congruences sharing a hidden solution, with some noise.
   task automatic random_system();
      int     len;
      longint target, modv, res;
      len = $urandom_range(1, 5);
      target = longint'({$urandom, $urandom} >> 2);
      for (int i = 0; i < len; i++) begin
         modv = pick_modulus();
         if ($urandom_range(0, 99) < 12)
            res = longint'({$urandom, $urandom});
         else if (modv > 0 && modv <= 2000)
            res = target + modv * ($urandom_range(0, 6) - 3);
         else if (modv > 0 && modv < MOD_MAX && $urandom_range(0, 1))
            res = target - modv;
         else
            res = target;
         send(res, modv, (i == 0) && ($urandom_range(0, 19) != 0), i == len - 1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no first item after reset, then keep merging into the kept state
      send(5, 7, 1'b0, 1'b1);
      send(3, 5, 1'b0, 1'b1);
      // field extremes
      send(RES_MIN, 1, 1'b1, 1'b1);
      send(MOD_MAX, MOD_MAX, 1'b1, 1'b1);
      send(-1, MOD_MAX, 1'b1, 1'b1);
      send(RES_MIN, 3, 1'b1, 1'b1);
      // non-positive moduli
      send(0, 0, 1'b1, 1'b1);
      send(1, -1, 1'b1, 1'b1);
      send(1, RES_MIN, 1'b1, 1'b1);
      // inconsistent pair, then a latched error that swallows later items
      send(1, 4, 1'b1, 1'b0);
      send(2, 6, 1'b0, 1'b1);
      send(1, 4, 1'b1, 1'b0);
      send(2, 6, 1'b0, 1'b0);
      send(3, 5, 1'b0, 1'b0);
      send(0, 0, 1'b0, 1'b1);
      // non-coprime moduli with a negative residue
      send(-7, 12, 1'b1, 1'b0);
      send(5, 18, 1'b0, 1'b1);
      // lcm overflow, once with the widest modulus and once from two big moduli
      send(0, MOD_MAX, 1'b1, 1'b0);
      send(1, 2, 1'b0, 1'b1);
      send(12345, 64'sh4000_0000_0000_0001, 1'b1, 1'b0);
      send(7, 64'sh0000_0001_0000_0003, 1'b0, 1'b1);

      // drain: hold the sender until every result has come back
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
         random_system();
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("[congruence_system_combiner_core] OK");
      else
         $display("[congruence_system_combiner_core] ERROR");
      $finish;
   end
endmodule

### sim.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_divider.sv
hw/rtl/csc_mulmod.sv
hw/rtl/congruence_system_combiner_core.sv
verif/csc_checker.sv
verif/tb.sv
